[src/block_noise_gate_top_macros.svh]
// assertion macros for the block noise gate
`ifndef BLOCK_NOISE_GATE_TOP_MACROS_SVH
`define BLOCK_NOISE_GATE_TOP_MACROS_SVH

// same-cycle implication, checked out of reset
`define BNG_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define BNG_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/bng_pkg.sv]
// shared types and constants of the block noise gate
`default_nettype none
package bng_pkg;

  localparam int CH_W       = 3;
  localparam int SAMPLE_W   = 24;
  localparam int THRESH_W   = 23;
  localparam int HOLD_W     = 16;
  localparam int FPB_W      = 13;
  localparam int GAIN_W     = 17;
  localparam int CFG_DATA_W = 23;
  localparam int CFG_ADDR_W = 2;

  localparam logic [GAIN_W-1:0] UNITY      = 17'h10000;
  localparam logic [HOLD_W-1:0] SILENT_MAX = 16'hFFFF;

  localparam logic [THRESH_W-1:0] THRESH_RST = 23'd1;
  localparam logic [HOLD_W-1:0]   HOLD_RST   = 16'd0;
  localparam logic [FPB_W-1:0]    FPB_RST    = 13'd256;
  localparam logic [GAIN_W-1:0]   STEP_RST   = 17'd257;

  typedef enum logic [1:0] {
    MODE_OPEN    = 2'd0,
    MODE_CLOSED  = 2'd1,
    MODE_CLOSING = 2'd2,
    MODE_OPENING = 2'd3
  } gate_mode_t;

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_THRESHOLD        = 2'd0,
    CFG_HOLD_BLOCKS      = 2'd1,
    CFG_FRAMES_PER_BLOCK = 2'd2,
    CFG_RAMP_STEP        = 2'd3
  } cfg_reg_t;

  // per-channel state kept in memory, frame position stored beside it
  typedef struct packed {
    gate_mode_t          gate;
    logic [HOLD_W-1:0]   silent;
    logic                loud;
    logic [GAIN_W-1:0]   gain;
  } chan_state_t;

  typedef struct packed {
    logic [THRESH_W-1:0] threshold;
    logic [HOLD_W-1:0]   hold_blocks;
    logic [FPB_W-1:0]    frames_per_block;
    logic [GAIN_W-1:0]   ramp_step;
  } cfg_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    gate_mode_t                 mode;
    logic                       blk_end;
  } result_t;

endpackage
`default_nettype wire

[src/bng_if.sv]
// stream interfaces for the sample and result channels
`default_nettype none
interface bng_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  channel;
  logic [23:0] sample_in;

  modport source (output valid, output channel, output sample_in, input ready);
  modport sink   (input valid, input channel, input sample_in, output ready);
endinterface

interface bng_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  channel_out;
  logic [23:0] sample_out;
  logic [1:0]  gate_mode;
  logic        block_end;

  modport source (output valid, output channel_out, output sample_out,
                  output gate_mode, output block_end, input ready);
  modport sink   (input valid, input channel_out, input sample_out,
                  input gate_mode, input block_end, output ready);
endinterface
`default_nettype wire

[src/bng_state_mem.sv]
// per-channel state memory with valid bits and write-to-read forwarding
`default_nettype none
module bng_state_mem #(
  parameter int DEPTH = 8,
  parameter int AW    = 3,
  parameter int DW    = 64
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          rd_en,
  input  wire logic [AW-1:0] rd_addr,
  output logic [DW-1:0]      rd_data,
  input  wire logic          wr_en,
  input  wire logic [AW-1:0] wr_addr,
  input  wire logic [DW-1:0] wr_data
);

  logic [DW-1:0]    mem_r [DEPTH];
  logic [DEPTH-1:0] vld_r;
  logic [DW-1:0]    rd_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (wr_en) begin
      vld_r[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  // a write at the same edge wins over the stored copy
  always_ff @(posedge clk) begin
    if (rd_en) begin
      if (wr_en && (wr_addr == rd_addr)) begin
        rd_data_r <= wr_data;
      end else if (vld_r[rd_addr]) begin
        rd_data_r <= mem_r[rd_addr];
      end else begin
        rd_data_r <= '0;
      end
    end
  end

  assign rd_data = rd_data_r;

endmodule
`default_nettype wire

[src/bng_update.sv]
// gate datapath: gain scaling and per-channel state update for one sample
`default_nettype none
module bng_update import bng_pkg::*; #(
  parameter int MAX_FRAMES = 4096,
  parameter int POS_W      = 12
) (
  input  wire cfg_t                        cfg,
  input  wire logic                        in_range,
  input  wire logic signed [SAMPLE_W-1:0]  sample,
  input  wire chan_state_t                 cur,
  input  wire logic [POS_W-1:0]            cur_pos,
  output chan_state_t                      nxt,
  output logic [POS_W-1:0]                 nxt_pos,
  output result_t                          res
);

  localparam int CMP_W = ((POS_W + 1) > FPB_W) ? (POS_W + 1) : FPB_W;
  localparam int PROD_W = GAIN_W + 1 + SAMPLE_W;

  logic [CMP_W-1:0]           fpb_ext;
  logic [CMP_W-1:0]           frames;
  logic [CMP_W-1:0]           frames_m1;
  logic                       blk_end;
  logic [GAIN_W-1:0]          step;
  logic [GAIN_W-1:0]          gain;
  logic [SAMPLE_W-1:0]        mag;
  logic                       loud_now;
  logic                       loud_n;
  logic signed [PROD_W-1:0]   prod;
  logic signed [SAMPLE_W-1:0] scaled;
  logic signed [SAMPLE_W-1:0] y;
  logic [GAIN_W-1:0]          gain_n;
  logic [HOLD_W-1:0]          silent_inc;

  always_comb begin
    fpb_ext = CMP_W'(cfg.frames_per_block);
    if (fpb_ext < CMP_W'(2)) begin
      frames = CMP_W'(2);
    end else if (fpb_ext > CMP_W'(MAX_FRAMES)) begin
      frames = CMP_W'(MAX_FRAMES);
    end else begin
      frames = fpb_ext;
    end
    frames_m1 = frames - CMP_W'(1);
    blk_end   = (CMP_W'(cur_pos) >= frames_m1);
  end

  assign step = (cfg.ramp_step > UNITY) ? UNITY : cfg.ramp_step;
  assign gain = (cur.gain > UNITY) ? UNITY : cur.gain;

  assign mag      = sample[SAMPLE_W-1] ? (~sample + SAMPLE_W'(1)) : sample;
  assign loud_now = (mag > {1'b0, cfg.threshold});

  // gain never exceeds unity so the floored product fits the sample width
  assign prod   = $signed({1'b0, gain}) * sample;
  assign scaled = prod[SAMPLE_W+15:16];

  assign silent_inc = (cur.silent != SILENT_MAX) ? (cur.silent + HOLD_W'(1)) : cur.silent;

  always_comb begin
    y      = scaled;
    loud_n = cur.loud;
    gain_n = cur.gain;
    case (cur.gate)
      MODE_OPEN: begin
        y      = sample;
        loud_n = cur.loud | loud_now;
      end
      MODE_CLOSED: begin
        y      = '0;
        loud_n = cur.loud | loud_now;
      end
      MODE_CLOSING: begin
        gain_n = (gain > step) ? (gain - step) : '0;
      end
      MODE_OPENING: begin
        gain_n = ((UNITY - gain) > step) ? (gain + step) : UNITY;
      end
      default: begin
        y = scaled;
      end
    endcase
  end

  always_comb begin
    nxt      = cur;
    nxt.loud = loud_n;
    nxt.gain = gain_n;
    nxt_pos  = cur_pos + POS_W'(1);
    if (blk_end) begin
      nxt_pos  = '0;
      nxt.loud = 1'b0;
      case (cur.gate)
        MODE_OPEN: begin
          if (loud_n) begin
            nxt.silent = '0;
          end else begin
            nxt.silent = silent_inc;
            if (silent_inc >= cfg.hold_blocks) begin
              nxt.gate = MODE_CLOSING;
              nxt.gain = UNITY;
            end
          end
        end
        MODE_CLOSED: begin
          if (loud_n) begin
            nxt.silent = '0;
            nxt.gate   = MODE_OPENING;
            nxt.gain   = '0;
          end
        end
        MODE_CLOSING: begin
          nxt.gate = MODE_CLOSED;
        end
        MODE_OPENING: begin
          nxt.gate = MODE_OPEN;
        end
        default: begin
          nxt.gate = MODE_OPEN;
        end
      endcase
    end
  end

  // channels past the configured count leave state alone and read as closed
  always_comb begin
    if (in_range) begin
      res.sample  = y;
      res.mode    = cur.gate;
      res.blk_end = blk_end;
    end else begin
      res.sample  = '0;
      res.mode    = MODE_CLOSED;
      res.blk_end = 1'b0;
    end
  end

endmodule
`default_nettype wire

[src/block_noise_gate_top.sv]
// top level of the multichannel block noise gate
// path: the input transfer reads state memory into the update stage, then the result register holds the result
// throughput: one sample per cycle unless the output stalls, one state read and one write-back per cycle
//   with forwarding for back-to-back samples of one channel; a stalled result register lets one more sample wait
// reset: synchronous active-low rst_n clears pipeline valids and state-memory valid bits and
//   loads configuration defaults; no clearing pass, the block is ready right after reset
`default_nettype none
`include "block_noise_gate_top_macros.svh"
module block_noise_gate_top import bng_pkg::*; #(
  parameter int CHANNELS   = 8,
  parameter int MAX_FRAMES = 4096
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  bng_in_if.sink                     in_s,
  bng_out_if.source                  out_m,
  input  wire logic                  cfg_wr_en,
  input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  // memory geometry follows the channel count and the longest block
  localparam int AW       = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int CH_EXT_W = (AW > CH_W) ? AW : CH_W;
  localparam int POS_W    = $clog2(MAX_FRAMES);
  localparam int DW       = $bits(chan_state_t) + POS_W;

  // configuration registers
  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.threshold        <= THRESH_RST;
      cfg_r.hold_blocks      <= HOLD_RST;
      cfg_r.frames_per_block <= FPB_RST;
      cfg_r.ramp_step        <= STEP_RST;
    end else if (cfg_wr_en) begin
      case (cfg_reg_t'(cfg_addr))
        CFG_THRESHOLD:        cfg_r.threshold        <= cfg_data[THRESH_W-1:0];
        CFG_HOLD_BLOCKS:      cfg_r.hold_blocks      <= cfg_data[HOLD_W-1:0];
        CFG_FRAMES_PER_BLOCK: cfg_r.frames_per_block <= cfg_data[FPB_W-1:0];
        CFG_RAMP_STEP:        cfg_r.ramp_step        <= cfg_data[GAIN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // handshake: the update stage moves on whenever the result register is free or drains
  logic in_xfer;
  logic s1_adv;
  logic s1_v_r;
  logic out_v_r;

  assign s1_adv     = s1_v_r && (!out_v_r || out_m.ready);
  assign in_s.ready = !s1_v_r || s1_adv;
  assign in_xfer    = in_s.valid && in_s.ready;

  // channel decode: out-of-range channels skip the memory entirely
  logic [CH_EXT_W-1:0] ch_ext;
  logic                in_range;
  logic [AW-1:0]       in_addr;

  assign ch_ext   = CH_EXT_W'(in_s.channel);
  assign in_range = ({1'b0, ch_ext} < (CH_EXT_W + 1)'(CHANNELS));
  assign in_addr  = ch_ext[AW-1:0];

  // update stage registers, filled on the transfer together with the memory read
  logic [CH_W-1:0]            s1_ch_r;
  logic signed [SAMPLE_W-1:0] s1_sample_r;
  logic                       s1_inr_r;
  logic [AW-1:0]              s1_addr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_xfer) begin
      s1_v_r <= 1'b1;
    end else if (s1_adv) begin
      s1_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_ch_r     <= in_s.channel;
      s1_sample_r <= $signed(in_s.sample_in);
      s1_inr_r    <= in_range;
      s1_addr_r   <= in_addr;
    end
  end

  // state memory: read at the transfer, written back when the update stage advances
  logic [DW-1:0]      rd_data;
  logic [DW-1:0]      wr_data;
  logic               mem_we;
  chan_state_t        cur_state;
  logic [POS_W-1:0]   cur_pos;
  chan_state_t        upd_state;
  logic [POS_W-1:0]   upd_pos;
  result_t            upd_res;

  assign mem_we  = s1_adv && s1_inr_r;
  assign wr_data = {upd_state, upd_pos};

  bng_state_mem #(
    .DEPTH (CHANNELS),
    .AW    (AW),
    .DW    (DW)
  ) u_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (in_xfer && in_range),
    .rd_addr (in_addr),
    .rd_data (rd_data),
    .wr_en   (mem_we),
    .wr_addr (s1_addr_r),
    .wr_data (wr_data)
  );

  assign cur_state = chan_state_t'(rd_data[DW-1:POS_W]);
  assign cur_pos   = rd_data[POS_W-1:0];

  // gain multiply and block bookkeeping
  bng_update #(
    .MAX_FRAMES (MAX_FRAMES),
    .POS_W      (POS_W)
  ) u_upd (
    .cfg      (cfg_r),
    .in_range (s1_inr_r),
    .sample   (s1_sample_r),
    .cur      (cur_state),
    .cur_pos  (cur_pos),
    .nxt      (upd_state),
    .nxt_pos  (upd_pos),
    .res      (upd_res)
  );

  // result register, decouples the update stage from the downstream ready
  logic [CH_W-1:0]     out_ch_r;
  logic [SAMPLE_W-1:0] out_sample_r;
  gate_mode_t          out_mode_r;
  logic                out_end_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (s1_adv) begin
      out_v_r <= 1'b1;
    end else if (out_m.ready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_ch_r     <= s1_ch_r;
      out_sample_r <= upd_res.sample;
      out_mode_r   <= upd_res.mode;
      out_end_r    <= upd_res.blk_end;
    end
  end

  assign out_m.valid       = out_v_r;
  assign out_m.channel_out = out_ch_r;
  assign out_m.sample_out  = out_sample_r;
  assign out_m.gate_mode   = out_mode_r;
  assign out_m.block_end   = out_end_r;

  // checks on the pipeline and the gate datapath
  `BNG_ASSERT_NEXT(a_s1_holds, s1_v_r && !s1_adv, s1_v_r && $stable(s1_ch_r), "update stage lost a stalled sample")
  `BNG_ASSERT_NEXT(a_xfer_fills_s1, in_xfer, s1_v_r, "input transfer did not reach the update stage")
  `BNG_ASSERT_NOW(a_oor_quiet, s1_v_r && !s1_inr_r, (upd_res.sample == '0) && !upd_res.blk_end && !mem_we, "out-of-range channel touched state or output")
  `BNG_ASSERT_NOW(a_closing_falls, s1_v_r && s1_inr_r && (cur_state.gate == MODE_CLOSING) && (cur_state.gain <= UNITY), upd_state.gain <= cur_state.gain, "closing ramp gain rose")

endmodule
`default_nettype wire
